>>> rtl/core/combinatorics_unit_macros.svh
// combinatorics_unit_macros.svh: assertion macros for the combinatorics unit
// no dependencies; included by files that carry concurrent assertions
`ifndef COMBINATORICS_UNIT_MACROS_SVH
`define COMBINATORICS_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("combinatorics_unit check failed");

// next-cycle implication, disabled during reset
`define CU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("combinatorics_unit check failed");

`endif

>>> rtl/core/cmb_pkg.sv
// cmb_pkg: types, codes and datapath widths of the combinatorics unit
// no dependencies; used by combinatorics_unit
package cmb_pkg;

  // operand and datapath widths
  localparam int OPERAND_WIDTH_DEF   = 16;
  localparam int FACTORIAL_LIMIT_DEF = 20;
  localparam int FIELD_W = 16;
  localparam int MUL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = ACC_W + MUL_W;
  localparam int BIT_W   = $clog2(PROD_W);

  // operation codes
  localparam logic [1:0] FN_FACT = 2'd0;
  localparam logic [1:0] FN_PERM = 2'd1;
  localparam logic [1:0] FN_COMB = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // command transfer payload
  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] n;
    logic [FIELD_W-1:0] r;
  } cmd_t;

  // result transfer payload
  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic [1:0]       status;
  } res_t;

endpackage

>>> rtl/core/combinatorics_unit.sv
// combinatorics_unit: factorial, nPr and nCr on a shared 32x32 multiplier and a
// bit-serial 96/OPERAND_WIDTH divider; depends on cmb_pkg and the macro header
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  command  | start / busy       | cmd  (func, n, r)
//  result   | done strobe        | res  (value, status)
//
// each multiply term sends the low then the high half of the accumulator
// through the one 32x32 multiplier; nCr adds a 96-bit restoring division per
// term. the done strobe follows the last term (or the command transfer, for an
// invalid command or zero terms), and busy drops in the cycle after done.
// rst is synchronous and returns the sequencer to idle. results cannot be
// stalled: done is high for exactly one cycle per command.
`include "combinatorics_unit_macros.svh"

module combinatorics_unit #(
  parameter int OPERAND_WIDTH   = cmb_pkg::OPERAND_WIDTH_DEF,
  parameter int FACTORIAL_LIMIT = cmb_pkg::FACTORIAL_LIMIT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cmb_pkg::cmd_t cmd,
  output logic          done,
  output cmb_pkg::res_t res
);

  localparam int OW = OPERAND_WIDTH;
  localparam logic [cmb_pkg::BIT_W-1:0] BIT_LAST = cmb_pkg::BIT_W'(cmb_pkg::PROD_W - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]                  state;
  logic [1:0]                  func;
  logic [1:0]                  status;
  logic [cmb_pkg::ACC_W-1:0]   acc;
  logic [cmb_pkg::PROD_W-1:0]  work;
  logic [OW-1:0]               mterm;
  logic [OW-1:0]               dvsr;
  logic [OW-1:0]               cnt;
  logic [OW-1:0]               rem;
  logic [cmb_pkg::BIT_W-1:0]   bitc;

  // command decode
  logic [OW-1:0] n_in;
  logic [OW-1:0] r_in;
  logic [OW-1:0] r_fold;
  logic [OW-1:0] cnt_in;
  logic          inv_in;

  assign n_in   = OW'(cmd.n);
  assign r_in   = OW'(cmd.r);
  assign r_fold = (r_in > (n_in >> 1)) ? (n_in - r_in) : r_in;

  always_comb begin
    cnt_in = '0;
    inv_in = 1'b0;
    unique case (cmd.func)
      cmb_pkg::FN_FACT: begin
        if (n_in > OW'(FACTORIAL_LIMIT)) inv_in = 1'b1;
        else cnt_in = n_in;
      end
      cmb_pkg::FN_PERM: begin
        if (r_in > n_in) inv_in = 1'b1;
        else cnt_in = r_in;
      end
      cmb_pkg::FN_COMB: begin
        if (r_in > n_in) inv_in = 1'b1;
        else cnt_in = r_fold;
      end
      default: inv_in = 1'b1;
    endcase
  end

  // shared multiplier, one accumulator half per cycle
  logic [cmb_pkg::MUL_W-1:0]   mul_a;
  logic [cmb_pkg::MUL_W-1:0]   mul_b;
  logic [2*cmb_pkg::MUL_W-1:0] mp;
  logic [cmb_pkg::PROD_W-1:0]  prod_sum;

  assign mul_a    = (state == S_MUL_LO) ? acc[cmb_pkg::MUL_W-1:0]
                                        : acc[cmb_pkg::ACC_W-1:cmb_pkg::MUL_W];
  assign mul_b    = cmb_pkg::MUL_W'(mterm);
  assign mp       = mul_a * mul_b;
  assign prod_sum = work + {mp, {cmb_pkg::MUL_W{1'b0}}};

  // restoring divide step
  logic [OW:0]                trial;
  logic [OW:0]                diff;
  logic                       qbit;
  logic [OW-1:0]              rem_next;
  logic [cmb_pkg::PROD_W-1:0] quot;

  assign trial    = {rem, work[cmb_pkg::PROD_W-1]};
  assign diff     = trial - {1'b0, dvsr};
  assign qbit     = (trial >= {1'b0, dvsr});
  assign rem_next = qbit ? diff[OW-1:0] : trial[OW-1:0];
  assign quot     = {work[cmb_pkg::PROD_W-2:0], qbit};

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            func   <= cmd.func;
            mterm  <= n_in;
            dvsr   <= OW'(1);
            cnt    <= cnt_in;
            acc    <= inv_in ? '0 : cmb_pkg::ACC_W'(1);
            status <= inv_in ? cmb_pkg::ST_INVALID : cmb_pkg::ST_OK;
            state  <= (inv_in || cnt_in == '0) ? S_DONE : S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          work  <= {{cmb_pkg::MUL_W{1'b0}}, mp};
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          if (func == cmb_pkg::FN_COMB) begin
            work  <= prod_sum;
            rem   <= '0;
            bitc  <= '0;
            state <= S_DIV;
          end else begin
            acc   <= prod_sum[cmb_pkg::ACC_W-1:0];
            cnt   <= cnt - OW'(1);
            mterm <= mterm - OW'(1);
            dvsr  <= dvsr + OW'(1);
            state <= (cnt == OW'(1)) ? S_DONE : S_MUL_LO;
          end
        end
        S_DIV: begin
          work <= quot;
          rem  <= rem_next;
          bitc <= bitc + cmb_pkg::BIT_W'(1);
          if (bitc == BIT_LAST) begin
            if (quot[cmb_pkg::PROD_W-1:cmb_pkg::ACC_W] != '0) begin
              acc    <= '0;
              status <= cmb_pkg::ST_OVERFLOW;
              state  <= S_DONE;
            end else begin
              acc   <= quot[cmb_pkg::ACC_W-1:0];
              cnt   <= cnt - OW'(1);
              mterm <= mterm - OW'(1);
              dvsr  <= dvsr + OW'(1);
              state <= (cnt == OW'(1)) ? S_DONE : S_MUL_LO;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign res.value  = acc;
  assign res.status = status;

  // checks
  `CU_ASSERT_NOW(a_err_zero, clk, rst, done && res.status != cmb_pkg::ST_OK, res.value == '0)
  `CU_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  `CU_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy)
  `CU_ASSERT_NOW(a_div_nonzero, clk, rst, state == S_DIV, dvsr != '0)

endmodule
